// File: rtl/core/double_ended_queue_unit_assert.svh
// Assertion macros for the double-ended queue unit.
// Included by the modules that carry assertions; expects i_clk and i_rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define DEQU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DEQU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dequ_pkg.sv
// Shared types and constants for the double-ended queue unit.
// No dependencies.
`timescale 1ns / 1ps

package dequ_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/core/dequ_ctrl.sv
// Sequencer for the double-ended queue unit: accept, execute, load result.
// Depends on dequ_pkg.
`timescale 1ns / 1ps

module dequ_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dequ_pkg::t_dp_stat i_stat,
    output dequ_pkg::t_dp_cmd  o_cmd
);
    import dequ_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/dequ_datapath.sv
// Ring buffer, head pointer, entry count and output register of the queue unit.
// Depends on dequ_pkg and double_ended_queue_unit_assert.svh.
`timescale 1ns / 1ps

module dequ_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dequ_pkg::t_dp_cmd                  i_cmd,
    output dequ_pkg::t_dp_stat                 o_stat,
    input  logic [1:0]                         i_opcode,
    input  logic signed [dequ_pkg::DATA_W-1:0] i_value,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic signed [dequ_pkg::DATA_W-1:0] o_popped_value,
    output logic [1:0]                         o_status,
    output logic [dequ_pkg::OCC_W-1:0]         o_occupancy
);
    import dequ_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    t_opcode           r_op;
    logic [DATA_W-1:0] r_val;
    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_pop_ok;
    t_status           r_res_status;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_popped;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    logic              is_push;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] cnt_lo;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;
    t_status           n_status;
    logic              wr_en;
    logic              rd_en;

    always_comb begin
        is_push  = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK);
        full     = (r_count == CNT_W'(DEPTH));
        empty    = (r_count == '0);
        cnt_lo   = r_count[ADDR_W-1:0];
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        case (r_op)
            OP_PUSH_FRONT: slot = r_head - ADDR_W'(1);
            OP_PUSH_BACK:  slot = r_head + cnt_lo;
            OP_POP_FRONT:  slot = r_head;
            OP_POP_BACK:   slot = r_head + cnt_lo - ADDR_W'(1);
            default:       slot = r_head;
        endcase
        if (is_push) begin
            if (full) begin
                n_status = ST_OVERFLOW;
            end else begin
                wr_en   = 1'b1;
                n_count = r_count + CNT_W'(1);
                if (r_op == OP_PUSH_FRONT) begin
                    n_head = slot;
                end
            end
        end else begin
            if (empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                rd_en   = 1'b1;
                n_count = r_count - CNT_W'(1);
                if (r_op == OP_POP_FRONT) begin
                    n_head = r_head + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[slot] <= r_val;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_opcode'(i_opcode);
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_pop_ok     <= rd_en;
            r_res_status <= n_status;
        end
        if (i_cmd.load) begin
            r_out_popped <= r_pop_ok ? r_rd_data : '0;
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_popped_value  = r_out_popped;
    assign o_status        = r_out_status;
    assign o_occupancy     = OCC_W'(r_out_count);

`include "double_ended_queue_unit_assert.svh"

    `DEQU_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `DEQU_ASSERT_NEXT(a_underflow, i_cmd.exec && !is_push && empty,
        (r_res_status == ST_UNDERFLOW) && (r_count == '0), "empty pop not flagged")
    `DEQU_ASSERT_NEXT(a_push_grows, i_cmd.exec && is_push && !full,
        r_count == $past(r_count) + CNT_W'(1), "push did not grow count")
    `DEQU_ASSERT_NOW(a_overflow_full, r_out_valid && (r_out_status == ST_OVERFLOW),
        r_out_count == CNT_W'(DEPTH), "overflow reported while not full")
    `DEQU_ASSERT_NOW(a_load_free, i_cmd.load, !r_out_valid || !i_out_stall,
        "result loaded over a held item")

endmodule

// File: rtl/core/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: sequencer plus ring-buffer datapath.
// Depends on dequ_pkg, dequ_ctrl and dequ_datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   request | in        | i_valid / o_stall  | i_opcode, i_value
//   result  | out       | o_valid / i_stall  | o_popped_value, o_status, o_occupancy
//
// An item goes through three steps: accept, ring-buffer access (registered read), result load.
// The single-port buffer access is done in its own cycle, so a new item is taken only
// once the previous item's result has been loaded into the result register.
// A held result delays the load step and o_stall stays high until it is handed off;
// only one further item can be accepted and executed while a result waits.
// Synchronous active-low reset empties the queue; buffer contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_opcode,
    input  logic signed [dequ_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [dequ_pkg::DATA_W-1:0] o_popped_value,
    output logic [1:0]                         o_status,
    output logic [dequ_pkg::OCC_W-1:0]         o_occupancy
);
    import dequ_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dequ_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dequ_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for double_ended_queue_unit: directed table, then biased random ops.
// Predicts results with its own ring-buffer deque or fixed table rows; checks field by field.
// Depends on dequ_pkg and the double_ended_queue_unit RTL.
`timescale 1ns / 1ps

module testbench;
    import dequ_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        t_status           status;
        logic [OCC_W-1:0]  occ;
    } t_deque_result;

    typedef struct packed {
        t_opcode           op;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] step;
        logic [7:0]        reps;
        logic              fixed;
        t_deque_result     expected;
    } t_stim_row;

    localparam int SCRIPT_LEN  = 13;
    localparam int RANDOM_ITEMS = 920;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_opcode = 2'd0;
    logic signed [DATA_W-1:0]  i_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [DATA_W-1:0]  o_popped_value;
    logic [1:0]                o_status;
    logic [OCC_W-1:0]          o_occupancy;

    logic [DATA_W-1:0] ring [DEPTH];
    logic [ADDR_W-1:0] front_slot;
    logic [CNT_W-1:0]  fill_level;

    t_deque_result pending_results [$];
    t_stim_row     script [SCRIPT_LEN];

    int n_push = 0;
    int n_pop = 0;
    int n_underflow = 0;
    int n_overflow = 0;
    int n_checked = 0;
    int n_errors = 0;
    int burst_left = 0;
    int stall_cycle = 0;
    int stall_mode = 0;

    double_ended_queue_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_deque_result deque_apply(input t_opcode op, input logic [DATA_W-1:0] val);
        t_deque_result     r;
        logic [ADDR_W-1:0] slot;
        r.popped = '0;
        r.status = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (fill_level >= DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                if (op == OP_PUSH_FRONT) begin
                    front_slot = front_slot - 1'b1;
                    slot = front_slot;
                end else begin
                    slot = front_slot + fill_level[ADDR_W-1:0];
                end
                ring[slot] = val;
                fill_level = fill_level + 1'b1;
            end
        end else if (fill_level == 0) begin
            r.status = ST_UNDERFLOW;
        end else begin
            if (op == OP_POP_FRONT) begin
                r.popped = ring[front_slot];
                front_slot = front_slot + 1'b1;
            end else begin
                slot = front_slot + fill_level[ADDR_W-1:0] - 1'b1;
                r.popped = ring[slot];
            end
            fill_level = fill_level - 1'b1;
        end
        r.occ = fill_level;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_op(input t_opcode op, input logic [DATA_W-1:0] val,
                            input logic use_fixed, input t_deque_result fixed);
        t_deque_result predicted;
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predicted = deque_apply(op, val);
        pending_results.push_back(use_fixed ? fixed : predicted);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) n_push++;
        else n_pop++;
        if (predicted.status == ST_UNDERFLOW) n_underflow++;
        if (predicted.status == ST_OVERFLOW) n_overflow++;
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid  <= 1'b0;
                i_opcode <= $urandom_range(0, 3);
                i_value  <= $urandom;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // receiver stall pattern: one of five modes, re-chosen at random on a stall_cycle counter boundary
    always @(negedge i_clk) begin
        if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 4);
        stall_cycle++;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            3: i_stall <= (stall_cycle % 5 < 2);
            default: i_stall <= (stall_cycle % 32 >= 24);
        endcase
    end

    always @(posedge i_clk) begin
        t_deque_result exp_r;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result popped_value %h status %0d occupancy %0d",
                         $time, o_popped_value, o_status, o_occupancy);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (o_popped_value !== exp_r.popped) begin
                    $display("%0t: popped_value expected %h actual %h",
                             $time, exp_r.popped, o_popped_value);
                    n_errors++;
                end
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    n_errors++;
                end
                if (o_occupancy !== exp_r.occ) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, exp_r.occ, o_occupancy);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int      push_bias;
        int      phase_left;
        t_opcode op;
        logic [DATA_W-1:0] val;

        front_slot = '0;
        fill_level = '0;
        phase_left = 0;
        push_bias  = 50;

        script[0]  = '{OP_POP_FRONT,  32'h0, 32'h0, 8'd1, 1'b1, '{32'h0, ST_UNDERFLOW, 5'd0}};
        script[1]  = '{OP_POP_BACK,   32'h5, 32'h0, 8'd1, 1'b1, '{32'h0, ST_UNDERFLOW, 5'd0}};
        script[2]  = '{OP_PUSH_FRONT, 32'h8000_0000, 32'h0, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd1}};
        script[3]  = '{OP_PUSH_BACK,  32'h7FFF_FFFF, 32'h0, 8'd1, 1'b1, '{32'h0, ST_OK, 5'd2}};
        script[4]  = '{OP_POP_FRONT,  32'h0, 32'h0, 8'd1, 1'b1,
                       '{32'h8000_0000, ST_OK, 5'd1}};
        script[5]  = '{OP_POP_BACK,   32'h0, 32'h0, 8'd1, 1'b1,
                       '{32'h7FFF_FFFF, ST_OK, 5'd0}};
        script[6]  = '{OP_POP_BACK,   32'h0, 32'h0, 8'd1, 1'b1, '{32'h0, ST_UNDERFLOW, 5'd0}};
        // fill to full from both ends, wrapping the head below slot 0
        script[7]  = '{OP_PUSH_BACK,  32'hFFFF_FFFF, 32'h2000_0001, 8'd8, 1'b0, '0};
        script[8]  = '{OP_PUSH_FRONT, 32'h0, 32'h0000_0001, 8'd8, 1'b0, '0};
        script[9]  = '{OP_PUSH_FRONT, 32'h5555_5555, 32'h0, 8'd1, 1'b1,
                       '{32'h0, ST_OVERFLOW, 5'd16}};
        script[10] = '{OP_PUSH_BACK,  32'hAAAA_AAAA, 32'h0, 8'd1, 1'b1,
                       '{32'h0, ST_OVERFLOW, 5'd16}};
        script[11] = '{OP_POP_BACK,   32'h0, 32'h0, 8'd1, 1'b0, '0};
        script[12] = '{OP_POP_FRONT,  32'h0, 32'h0, 8'd1, 1'b0, '0};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            for (int k = 0; k < script[i].reps; k++) begin
                issue_op(script[i].op, script[i].base + k * script[i].step,
                         script[i].fixed, script[i].expected);
                sender_gap();
            end
        end
        drain_results();
        @(negedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 4))
                    0: push_bias = 90;
                    1: push_bias = 75;
                    2: push_bias = 50;
                    3: push_bias = 25;
                    default: push_bias = 10;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_bias)
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            case ($urandom_range(0, 7))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'h0;
                3: val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            issue_op(op, val, 1'b0, '0);
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
                @(negedge i_clk);
            end else begin
                sender_gap();
            end
        end

        drain_results();
        repeat (12) @(negedge i_clk);

        $display("Ran %0d pushes and %0d pops (%0d overflows, %0d underflows)",
                 n_push, n_pop, n_overflow, n_underflow);
        $display("Checked %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dequ_pkg.sv
rtl/core/dequ_ctrl.sv
rtl/core/dequ_datapath.sv
rtl/core/double_ended_queue_unit.sv
tb/sv/testbench.sv
